// File: sv/obrb_pkg.sv
// obrb_pkg: types, codes and constants shared by the overwriting byte ring buffer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package obrb_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CAP_W         = 7;
    localparam int AMT_W         = 7;
    localparam int MAX_RESULTS   = 64;
    localparam int CAP_RESET     = 64;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_GET   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       byte_in;
        logic [AMT_W-1:0] count;
        logic             consume;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             ok;
        logic [AMT_W-1:0] amount;
        logic             last;
    } out_item_t;

    typedef struct packed {
        cmd_t             op;
        logic [7:0]       byte_in;
        logic [AMT_W-1:0] count;
        logic             consume;
    } op_t;

endpackage

// File: sv/obrb_front.sv
// obrb_front: accepts input items, decodes the command and normalizes the request
// depends on obrb_pkg
`timescale 1ns / 1ps

module obrb_front (
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  obrb_pkg::in_item_t cmd_item,
    input  logic              q_full,
    output logic              q_push,
    output obrb_pkg::op_t     q_op
);

    assign cmd_ready = !q_full;
    assign q_push    = cmd_valid && !q_full;

    always_comb
    begin
        q_op.byte_in = cmd_item.byte_in;
        q_op.consume = cmd_item.consume;
        q_op.count   = cmd_item.count;
        unique case (cmd_item.cmd)
            2'(obrb_pkg::CMD_PUT):
            begin
                q_op.op = obrb_pkg::CMD_PUT;
            end
            2'(obrb_pkg::CMD_ERASE):
            begin
                q_op.op = obrb_pkg::CMD_ERASE;
            end
            2'(obrb_pkg::CMD_GET):
            begin
                // get is a consuming read of one byte
                q_op.op      = obrb_pkg::CMD_GET;
                q_op.count   = obrb_pkg::AMT_W'(1);
                q_op.consume = 1'b1;
            end
            default:
            begin
                q_op.op = obrb_pkg::CMD_READ;
                if (32'(cmd_item.count) > obrb_pkg::MAX_RESULTS)
                begin
                    q_op.count = obrb_pkg::AMT_W'(obrb_pkg::MAX_RESULTS);
                end
            end
        endcase
    end

endmodule

// File: sv/obrb_queue.sv
// obrb_queue: short queue of decoded commands between front and back
// depends on obrb_pkg
`timescale 1ns / 1ps

module obrb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  obrb_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output obrb_pkg::op_t head_op
);

    localparam int QD    = obrb_pkg::QUEUE_DEPTH;
    localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCNT_W = $clog2(QD + 1);

    obrb_pkg::op_t     entry_reg [QD];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full       = (32'(cnt_reg) == QD);
    assign head_valid = (cnt_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QD - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QD - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: sv/obrb_back.sv
// obrb_back: ring state, byte store and result sequencing with an output register
// depends on obrb_pkg
`timescale 1ns / 1ps

module obrb_back #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [obrb_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                       q_valid,
    input  obrb_pkg::op_t              q_op,
    output logic                       q_pop,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output obrb_pkg::out_item_t        rsp_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int AMT_W = obrb_pkg::AMT_W;
    localparam int RING_RESET =
        (obrb_pkg::CAP_RESET > DEPTH) ? DEPTH : obrb_pkg::CAP_RESET;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic             mem_re;
    logic [PTR_W-1:0] rd_addr;

    obrb_pkg::back_state_t state_reg;
    obrb_pkg::back_state_t state_next;
    logic [CNT_W-1:0] ring_reg;
    logic [CNT_W-1:0] ring_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [AMT_W-1:0] remain_reg;
    logic [AMT_W-1:0] remain_next;
    logic [AMT_W-1:0] amount_reg;
    logic [AMT_W-1:0] amount_next;
    logic             res_valid_reg;
    obrb_pkg::out_item_t res_reg;

    logic                can_emit;
    logic                emit;
    obrb_pkg::out_item_t emit_item;
    logic [SUM_W-1:0]    start_sum;
    logic [PTR_W-1:0]    start;
    logic [CNT_W-1:0]    fill_put;
    logic [AMT_W-1:0]    n_take;
    logic [31:0]         cap32;

    function automatic logic [PTR_W-1:0] ring_inc(
        input logic [PTR_W-1:0] p,
        input logic [CNT_W-1:0] r
    );
        ring_inc = (SUM_W'(p) + SUM_W'(1) == SUM_W'(r)) ? '0 : p + 1'b1;
    endfunction

    assign can_emit  = !res_valid_reg || rsp_ready;
    assign rsp_valid = res_valid_reg;
    assign rsp_item  = res_reg;

    // oldest byte sits fill entries behind the write position
    assign start_sum = SUM_W'(wp_reg) + SUM_W'(ring_reg) - SUM_W'(fill_reg);
    assign start     = (start_sum >= SUM_W'(ring_reg)) ?
                       PTR_W'(start_sum - SUM_W'(ring_reg)) : PTR_W'(start_sum);
    assign fill_put  = (fill_reg == ring_reg) ? ring_reg : fill_reg + 1'b1;
    assign n_take    = (32'(q_op.count) < 32'(fill_reg)) ? q_op.count : AMT_W'(fill_reg);
    assign cap32     = 32'(cfg_wdata);

    always_comb
    begin
        state_next  = state_reg;
        ring_next   = ring_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        remain_next = remain_reg;
        amount_next = amount_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = start;
        emit        = 1'b0;
        emit_item   = '{data_out: 8'd0, ok: 1'b0, amount: '0, last: 1'b1};

        if (cfg_we)
        begin
            if (cap32 == 32'd0)
            begin
                ring_next = CNT_W'(1);
            end
            else if (cap32 > DEPTH)
            begin
                ring_next = CNT_W'(DEPTH);
            end
            else
            begin
                ring_next = CNT_W'(cap32);
            end
            wp_next   = '0;
            fill_next = '0;
        end

        unique case (state_reg)
            obrb_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_op.op)
                        obrb_pkg::CMD_PUT:
                        begin
                            if (can_emit)
                            begin
                                q_pop        = 1'b1;
                                mem_we       = 1'b1;
                                wp_next      = ring_inc(wp_reg, ring_reg);
                                fill_next    = fill_put;
                                emit         = 1'b1;
                                emit_item.ok = (fill_put < ring_reg);
                            end
                        end
                        obrb_pkg::CMD_ERASE:
                        begin
                            if (can_emit)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (fill_reg != '0)
                                begin
                                    wp_next      = (wp_reg == '0) ?
                                                   PTR_W'(ring_reg - 1'b1) : wp_reg - 1'b1;
                                    fill_next    = fill_reg - 1'b1;
                                    emit_item.ok = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (n_take == '0)
                            begin
                                if (can_emit)
                                begin
                                    q_pop = 1'b1;
                                    emit  = 1'b1;
                                end
                            end
                            else
                            begin
                                q_pop       = 1'b1;
                                mem_re      = 1'b1;
                                rd_addr     = start;
                                rd_ptr_next = ring_inc(start, ring_reg);
                                remain_next = n_take;
                                amount_next = (q_op.op == obrb_pkg::CMD_READ) ? n_take : '0;
                                if (q_op.consume)
                                begin
                                    fill_next = fill_reg - CNT_W'(n_take);
                                end
                                state_next  = obrb_pkg::ST_READ;
                            end
                        end
                    endcase
                end
            end
            obrb_pkg::ST_READ:
            begin
                if (can_emit)
                begin
                    emit               = 1'b1;
                    emit_item.data_out = rd_data_reg;
                    emit_item.ok       = 1'b1;
                    emit_item.amount   = amount_reg;
                    emit_item.last     = (remain_reg == AMT_W'(1));
                    remain_next        = remain_reg - 1'b1;
                    if (remain_reg == AMT_W'(1))
                    begin
                        state_next = obrb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        rd_addr     = rd_ptr_reg;
                        rd_ptr_next = ring_inc(rd_ptr_reg, ring_reg);
                    end
                end
            end
            default:
            begin
                state_next = obrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obrb_pkg::ST_IDLE;
            ring_reg      <= CNT_W'(RING_RESET);
            wp_reg        <= '0;
            fill_reg      <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ring_reg   <= ring_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        amount_reg <= amount_next;
        if (emit)
        begin
            res_reg <= emit_item;
        end
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= q_op.byte_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ring_reg)
        else $error("fill exceeds ring size");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(wp_reg) < SUM_W'(ring_reg))
        else $error("write position outside ring");

    a_read_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == obrb_pkg::ST_READ |-> remain_reg != '0)
        else $error("read burst with nothing left");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && state_reg == obrb_pkg::ST_IDLE))
        else $error("queue popped outside idle");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !rsp_ready) |=> ($stable(res_reg) && res_valid_reg))
        else $error("pending item overwritten");

endmodule

// File: sv/overwriting_byte_ring_buffer.sv
// overwriting_byte_ring_buffer: top level, front decode, command queue and back end
// depends on obrb_pkg, obrb_front, obrb_queue, obrb_back
`timescale 1ns / 1ps
//
// channel    direction  handshake              payload
// cmd        in         cmd_valid/cmd_ready    obrb_pkg::in_item_t
// rsp        out        rsp_valid/rsp_ready    obrb_pkg::out_item_t
// cfg        in         cfg_we                 cfg_wdata (capacity)
//
// put and erase: one item per cycle unless the output stalls or a read is in progress, one result each
// get and block read: each byte is read from the store into a register, then issued as a result,
//   in order through the single read port of the byte store
// a two-entry command queue lets input items enter while the back end is busy
// reset clears the write position, fill and queue; store contents stay undefined until written
// a stalled result holds in the output register and the back end waits on it

module overwriting_byte_ring_buffer #(
    parameter int DEPTH = obrb_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [obrb_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  obrb_pkg::in_item_t         cmd_item,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output obrb_pkg::out_item_t        rsp_item
);

    logic          q_full;
    logic          q_push;
    obrb_pkg::op_t q_in_op;
    logic          q_pop;
    logic          q_valid;
    obrb_pkg::op_t q_head_op;

    obrb_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_in_op)
    );

    obrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_in_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head_op)
    );

    obrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_op      (q_head_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule
